// ===== hw/rtl/hill_pkg.sv =====
`timescale 1ns / 1ps

package hill_pkg;

  localparam int HILL_MAX_BLOCK = 4;
  localparam int KEY_DIM        = 4;
  localparam int LETTER_W       = 8;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_SIZE    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PAD_LETTER    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ZERO  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_ONE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_TWO   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_ROW_THREE = 3'd6;

  localparam logic [2:0]          RST_BLOCK_SIZE    = 3'd2;
  localparam logic [LETTER_W-1:0] RST_ALPHABET_SIZE = 8'd27;
  localparam logic [LETTER_W-1:0] RST_PAD_LETTER    = 8'd26;

  typedef struct packed {
    logic [LETTER_W-1:0] letter;
    logic                message_end;
  } in_word_t;

  typedef struct packed {
    logic [LETTER_W-1:0] code;
    logic                last;
  } out_word_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_MOD,
    ST_EMIT
  } state_t;

endpackage

// ===== hw/rtl/hill_cipher_encrypt_top.sv =====
`timescale 1ns / 1ps

// Hill cipher encryptor. Letters are buffered until a block of block_size
// letters is complete (or message_end closes it, padded with pad_letter);
// nothing is emitted for a letter that leaves the block open. A closing
// letter starts the sequencer: for each of the n cipher words, the n
// products are summed on the shared 8x8 multiply-accumulate unit, then the
// SUM_W-bit sum is reduced bit by bit on the bit-serial remainder unit
// (SUM_W = 18 at MAX_BLOCK 4), then the word is handed to the output
// register once it is free. The output register lets the sequencer run
// ahead by one word. in_ready is high only while the sequencer is idle;
// cfg_ready is always high, and registers may be written only while the
// block is idle.
module hill_cipher_encrypt_top
  import hill_pkg::*;
#(
  parameter int MAX_BLOCK = HILL_MAX_BLOCK
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_word_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_word_t             out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_BLOCK > 1) ? $clog2(MAX_BLOCK) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCK + 1);
  localparam int SUM_W = 2 * LETTER_W + $clog2(MAX_BLOCK);
  localparam int BIT_W = $clog2(SUM_W);

  // configuration
  logic [2:0]            block_size_r;
  logic [LETTER_W-1:0]   alphabet_size_r;
  logic [LETTER_W-1:0]   pad_letter_r;
  logic [CFG_DATA_W-1:0] key_r [KEY_DIM];

  // sequencer and datapath
  state_t                state_r, state_nxt;
  logic [LETTER_W-1:0]   buf_r [MAX_BLOCK];
  logic [CNT_W-1:0]      fill_r, fill_nxt;
  logic [CNT_W-1:0]      pos_r, pos_nxt;
  logic                  end_r, end_nxt;
  logic [IDX_W-1:0]      z_r, z_nxt;
  logic [IDX_W-1:0]      j_r, j_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic [SUM_W-1:0]      div_r, div_nxt;
  logic [LETTER_W-1:0]   rem_r, rem_nxt;
  logic [BIT_W-1:0]      bit_r, bit_nxt;
  logic                  out_valid_r, out_valid_nxt;
  out_word_t             out_data_r, out_data_nxt;

  logic [CNT_W-1:0]      eff_size;
  logic [CNT_W-1:0]      size_m1;
  logic [CNT_W-1:0]      pos_in;
  logic                  in_fire;
  logic                  open_block;
  logic                  buf_we;
  logic [LETTER_W-1:0]   vec_val;
  logic [LETTER_W-1:0]   key_val;
  logic [1:0]            key_row;
  logic [1:0]            key_col;
  logic [2*LETTER_W-1:0] prod;
  logic [SUM_W-1:0]      acc_sum;
  logic [LETTER_W:0]     rem_try;
  logic [LETTER_W:0]     rem_sub;
  logic                  out_free;
  logic                  last_col;
  logic                  last_row;

  always_comb begin
    if (block_size_r == 3'd0) begin
      eff_size = CNT_W'(1);
    end else if (int'(block_size_r) > MAX_BLOCK) begin
      eff_size = CNT_W'(MAX_BLOCK);
    end else begin
      eff_size = CNT_W'(block_size_r);
    end
  end

  assign in_ready   = (state_r == ST_IDLE);
  assign size_m1    = eff_size - CNT_W'(1);
  assign pos_in     = (fill_r > size_m1) ? size_m1 : fill_r;
  assign in_fire    = in_valid && in_ready;
  assign open_block = (pos_in < size_m1) && !in_data.message_end;
  assign buf_we     = in_fire;
  assign last_col   = (CNT_W'(j_r) == size_m1);
  assign last_row   = (CNT_W'(z_r) == size_m1);
  assign out_free   = !out_valid_r || out_ready;

  // row vector entry z: buffered letters up to the closing one, then pad
  assign vec_val = (CNT_W'(z_r) <= pos_r) ? buf_r[z_r] : pad_letter_r;

  // key entries outside the 4x4 register set read as zero
  always_comb begin
    key_row = 2'(z_r);
    key_col = 2'(j_r);
    if (int'(z_r) < KEY_DIM && int'(j_r) < KEY_DIM) begin
      key_val = key_r[key_row][LETTER_W*key_col +: LETTER_W];
    end else begin
      key_val = '0;
    end
  end

  assign prod    = vec_val * key_val;
  assign acc_sum = acc_r + SUM_W'(prod);

  // one restoring step of the remainder
  assign rem_try = {rem_r, div_r[SUM_W-1]};
  assign rem_sub = rem_try - {1'b0, alphabet_size_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire && !open_block) begin
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        if (last_row) begin
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (bit_r == '0) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          state_nxt = last_col ? ST_IDLE : ST_MAC;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    end_nxt       = end_r;
    z_nxt         = z_r;
    j_nxt         = j_r;
    acc_nxt       = acc_r;
    div_nxt       = div_r;
    rem_nxt       = rem_r;
    bit_nxt       = bit_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (open_block) begin
            fill_nxt = pos_in + CNT_W'(1);
          end else begin
            fill_nxt = '0;
            pos_nxt  = pos_in;
            end_nxt  = in_data.message_end;
            z_nxt    = '0;
            j_nxt    = '0;
            acc_nxt  = '0;
          end
        end
      end
      ST_MAC: begin
        acc_nxt = acc_sum;
        z_nxt   = z_r + IDX_W'(1);
        if (last_row) begin
          div_nxt = acc_sum;
          rem_nxt = '0;
          bit_nxt = BIT_W'(SUM_W - 1);
        end
      end
      ST_MOD: begin
        div_nxt = {div_r[SUM_W-2:0], 1'b0};
        bit_nxt = bit_r - BIT_W'(1);
        rem_nxt = rem_sub[LETTER_W] ? rem_try[LETTER_W-1:0] : rem_sub[LETTER_W-1:0];
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_nxt     = 1'b1;
          // modulus zero yields zero
          out_data_nxt.code = (alphabet_size_r == '0) ? '0 : rem_r;
          out_data_nxt.last = end_r && last_col;
          j_nxt             = j_r + IDX_W'(1);
          z_nxt             = '0;
          acc_nxt           = '0;
        end
      end
      default: ;
    endcase
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      block_size_r    <= RST_BLOCK_SIZE;
      alphabet_size_r <= RST_ALPHABET_SIZE;
      pad_letter_r    <= RST_PAD_LETTER;
      for (int i = 0; i < KEY_DIM; i++) begin
        key_r[i] <= '0;
      end
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_BLOCK_SIZE:    block_size_r    <= cfg_data[2:0];
        CFG_ALPHABET_SIZE: alphabet_size_r <= cfg_data[LETTER_W-1:0];
        CFG_PAD_LETTER:    pad_letter_r    <= cfg_data[LETTER_W-1:0];
        CFG_KEY_ROW_ZERO:  key_r[0]        <= cfg_data;
        CFG_KEY_ROW_ONE:   key_r[1]        <= cfg_data;
        CFG_KEY_ROW_TWO:   key_r[2]        <= cfg_data;
        CFG_KEY_ROW_THREE: key_r[3]        <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_r      <= pos_nxt;
    end_r      <= end_nxt;
    z_r        <= z_nxt;
    j_r        <= j_nxt;
    acc_r      <= acc_nxt;
    div_r      <= div_nxt;
    rem_r      <= rem_nxt;
    bit_r      <= bit_nxt;
    out_data_r <= out_data_nxt;
    if (buf_we) begin
      buf_r[IDX_W'(pos_in)] <= in_data.letter;
    end
  end

endmodule

// ===== test/tb_hill_cipher_encrypt_top.sv =====
`timescale 1ns / 1ps

module tb_hill_cipher_encrypt_top;
  import hill_pkg::*;

  localparam int IDLE_PCT       = 27;
  localparam int CYCLE_LIMIT    = 400000;
  localparam int DRAIN_CYCLES   = 100;
  localparam int SETTLE_CYCLES  = 8;
  localparam int RANDOM_LETTERS = 130;

  // Tracks key, modulus and the open block; queues the cipher words each
  // accepted letter should produce.
  class hill_scoreboard;
    logic [2:0]          block_size;
    logic [LETTER_W-1:0] alphabet_size;
    logic [LETTER_W-1:0] pad_letter;
    logic [31:0]         key_row[KEY_DIM];
    logic [LETTER_W-1:0] held[HILL_MAX_BLOCK];
    int unsigned         fill_count;
    out_word_t           cipher_q[$];
    int                  errors;

    function new();
      block_size    = RST_BLOCK_SIZE;
      alphabet_size = RST_ALPHABET_SIZE;
      pad_letter    = RST_PAD_LETTER;
      foreach (key_row[i]) key_row[i] = '0;
      foreach (held[i]) held[i] = '0;
      fill_count = 0;
      errors     = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_BLOCK_SIZE:    block_size    = data[2:0];
        CFG_ALPHABET_SIZE: alphabet_size = data[LETTER_W-1:0];
        CFG_PAD_LETTER:    pad_letter    = data[LETTER_W-1:0];
        CFG_KEY_ROW_ZERO:  key_row[0]    = data;
        CFG_KEY_ROW_ONE:   key_row[1]    = data;
        CFG_KEY_ROW_TWO:   key_row[2]    = data;
        CFG_KEY_ROW_THREE: key_row[3]    = data;
        default: ;
      endcase
    endfunction

    function void note_letter(in_word_t w);
      int unsigned size;
      int unsigned pos;
      int unsigned sum;
      int unsigned vec[HILL_MAX_BLOCK];
      out_word_t   word;
      size = (block_size == 0) ? 1 :
             (block_size > HILL_MAX_BLOCK) ? HILL_MAX_BLOCK : block_size;
      // a shrunken block size clamps the write position
      pos = (fill_count > size - 1) ? size - 1 : fill_count;
      if (pos < size - 1 && !w.message_end) begin
        held[pos]  = w.letter;
        fill_count = pos + 1;
        return;
      end
      for (int z = 0; z < size; z++) begin
        if (z < pos) vec[z] = held[z];
        else if (z == pos) vec[z] = w.letter;
        else vec[z] = pad_letter;
      end
      for (int j = 0; j < size; j++) begin
        sum = 0;
        for (int z = 0; z < size; z++) sum += vec[z] * key_row[z][8*j +: 8];
        word.code = (alphabet_size == 0) ? '0 : LETTER_W'(sum % alphabet_size);
        word.last = w.message_end && (j == size - 1);
        cipher_q = {cipher_q, word};
      end
      fill_count = 0;
    endfunction

    function void check_code(out_word_t got);
      out_word_t want;
      if (cipher_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected word, expected none, got code %0d last %0b",
                 $time, got.code, got.last);
        return;
      end
      want = cipher_q.pop_front();
      if (got.code !== want.code) begin
        errors++;
        $display("%0t: code mismatch, expected %0d, got %0d", $time, want.code, got.code);
      end
      if (got.last !== want.last) begin
        errors++;
        $display("%0t: last mismatch, expected %0b, got %0b", $time, want.last, got.last);
      end
    endfunction

    function int pending();
      return cipher_q.size();
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  in_word_t              in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  out_word_t             out_data;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  hill_scoreboard sb = new();
  bit             steady = 1'b0;
  int             cycles = 0;
  int             sent = 0;
  logic [7:0]     alpha_now;

  hill_cipher_encrypt_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.write_reg(cfg_index, cfg_data);
      if (out_valid && out_ready) sb.check_code(out_data);
      if (in_valid && in_ready) sb.note_letter(in_data);
    end
  end

  task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // valid stays high across back-to-back words; dropped only for a gap
  task automatic send_letter(logic [7:0] letter, bit closing);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{letter, closing};
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_message(int len, bit closed);
    logic [7:0] letter;
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 9) == 0) letter = 8'($urandom_range(0, 254));
      else letter = 8'($urandom_range(0, alpha_now - 1));
      send_letter(letter, closed && (i == len - 1));
      sent++;
    end
  endtask

  initial begin
    int phase;
    int msgs;
    int r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset settings, all-zero key
    send_letter(8'd3, 1'b0);
    send_letter(8'd4, 1'b1);
    quiesce();

    // largest sums: full key, top letters, partial block padded
    set_reg(CFG_BLOCK_SIZE, 32'd4);
    set_reg(CFG_ALPHABET_SIZE, 32'd255);
    set_reg(CFG_PAD_LETTER, 32'd254);
    set_reg(CFG_KEY_ROW_ZERO, 32'hFFFF_FFFF);
    set_reg(CFG_KEY_ROW_ONE, 32'hFFFF_FFFF);
    set_reg(CFG_KEY_ROW_TWO, 32'hFFFF_FFFF);
    set_reg(CFG_KEY_ROW_THREE, 32'hFFFF_FFFF);
    for (int i = 0; i < 4; i++) send_letter(8'd254, 1'b0);
    for (int i = 0; i < 4; i++) send_letter(8'd0, i == 3);
    send_letter(8'd254, 1'b1);
    quiesce();

    // size zero acts as one; modulus zero, then one
    set_reg(CFG_BLOCK_SIZE, 32'd0);
    set_reg(CFG_ALPHABET_SIZE, 32'd0);
    set_reg(CFG_KEY_ROW_ZERO, $urandom);
    set_reg(CFG_KEY_ROW_ONE, $urandom);
    set_reg(CFG_KEY_ROW_TWO, $urandom);
    set_reg(CFG_KEY_ROW_THREE, $urandom);
    send_letter(8'd5, 1'b0);
    send_letter(8'd200, 1'b1);
    quiesce();
    set_reg(CFG_ALPHABET_SIZE, 32'd1);
    send_letter(8'd7, 1'b1);
    quiesce();

    // shrink the size with three letters held, then grow past the max
    set_reg(CFG_BLOCK_SIZE, 32'd4);
    set_reg(CFG_ALPHABET_SIZE, 32'd97);
    set_reg(CFG_PAD_LETTER, 32'd200);
    send_letter(8'd1, 1'b0);
    send_letter(8'd2, 1'b0);
    send_letter(8'd3, 1'b0);
    quiesce();
    set_reg(CFG_BLOCK_SIZE, 32'd2);
    send_letter(8'd9, 1'b0);
    send_letter(8'd11, 1'b0);
    quiesce();
    set_reg(CFG_BLOCK_SIZE, 32'd7);
    send_letter(8'd250, 1'b0);
    send_letter(8'd12, 1'b1);
    quiesce();

    phase = 0;
    while (sent < RANDOM_LETTERS) begin
      steady <= (phase == 2);
      r = $urandom_range(0, 9);
      if (r == 0) set_reg(CFG_BLOCK_SIZE, $urandom_range(0, 7));
      else set_reg(CFG_BLOCK_SIZE, $urandom_range(1, 4));
      case ($urandom_range(0, 3))
        0:       alpha_now = 8'd2;
        1:       alpha_now = 8'd255;
        default: alpha_now = 8'($urandom_range(3, 254));
      endcase
      set_reg(CFG_ALPHABET_SIZE, {24'd0, alpha_now});
      set_reg(CFG_PAD_LETTER, $urandom_range(0, 254));
      set_reg(CFG_KEY_ROW_ZERO, $urandom);
      set_reg(CFG_KEY_ROW_ONE, $urandom);
      set_reg(CFG_KEY_ROW_TWO, $urandom);
      set_reg(CFG_KEY_ROW_THREE, $urandom);
      msgs = $urandom_range(2, 4);
      // last message may stay open so the next settings hit a partial block
      for (int m = 0; m < msgs; m++)
        send_message($urandom_range(1, 9), (m != msgs - 1) || ($urandom_range(0, 9) >= 3));
      quiesce();
      phase++;
    end
    steady <= 1'b0;

    quiesce();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
